/* rtl/bbrb_pkg.sv */
// bbrb_pkg: shared widths, request codes and types for the burst byte ring buffer
// no dependencies; used by the interfaces, the controller, the top level and the checker

package bbrb_pkg;

    // field widths
    localparam int LEN_W   = 4;
    localparam int DATA_W  = 64;
    localparam int BYTE_W  = 8;
    localparam int FILL_W  = 8;
    localparam int SZ_W    = 9;
    localparam int TYPE_W  = 2;

    // parameter defaults
    localparam int DEPTH_DEF     = 256;
    localparam int MAX_BURST_DEF = 8;

    // largest slot count the pointers can reach
    localparam int SLOT_LIMIT = 256;

    // buffer size after reset
    localparam logic [SZ_W-1:0] SIZE_RESET = 9'd256;
    localparam logic [SZ_W-1:0] SIZE_MIN   = 9'd2;

    // request codes
    localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_READ  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd2;

    // configuration seen by the controller
    typedef struct packed {
        logic            clear;
        logic [SZ_W-1:0] size;
    } t_cfg;

endpackage

/* rtl/bbrb_if.sv */
// bbrb_req_if and bbrb_res_if: valid/ready channels for request and result items
// depends on bbrb_pkg for field widths

interface bbrb_req_if;
    logic                           valid;
    logic                           ready;
    logic [bbrb_pkg::TYPE_W-1:0]    req_type;
    logic [bbrb_pkg::LEN_W-1:0]     transfer_len;
    logic [bbrb_pkg::DATA_W-1:0]    write_data;

    modport source (output valid, output req_type, output transfer_len, output write_data,
                    input ready);
    modport sink   (input valid, input req_type, input transfer_len, input write_data,
                    output ready);
endinterface

interface bbrb_res_if;
    logic                           valid;
    logic                           ready;
    logic [bbrb_pkg::LEN_W-1:0]     accepted_len;
    logic [bbrb_pkg::BYTE_W-1:0]    read_byte;
    logic                           is_last;
    logic [bbrb_pkg::FILL_W-1:0]    fill_level;

    modport source (output valid, output accepted_len, output read_byte, output is_last,
                    output fill_level, input ready);
    modport sink   (input valid, input accepted_len, input read_byte, input is_last,
                    input fill_level, output ready);
endinterface

/* rtl/bbrb_ram.sv */
// bbrb_ram: generic single-port synchronous RAM with registered read data
// no dependencies; read data holds until the next read

module bbrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one access a cycle, read or write
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bbrb_ctrl.sv */
// bbrb_ctrl: pointers, request sequencer and result register of the ring buffer
// depends on bbrb_pkg and the two channel interfaces; drives the byte store port

module bbrb_ctrl #(
    parameter int SLOTS     = bbrb_pkg::SLOT_LIMIT,
    parameter int MAX_BURST = bbrb_pkg::MAX_BURST_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bbrb_pkg::t_cfg              i_cfg,
    bbrb_req_if.sink                    i_req,
    bbrb_res_if.source                  o_res,
    output logic                        o_ram_en,
    output logic                        o_ram_we,
    output logic [$clog2(SLOTS)-1:0]    o_ram_addr,
    output logic [bbrb_pkg::BYTE_W-1:0] o_ram_wdata,
    input  logic [bbrb_pkg::BYTE_W-1:0] i_ram_rdata
);

    localparam int PTR_W  = $clog2(SLOTS);
    localparam int LEN_W  = bbrb_pkg::LEN_W;
    localparam int SZ_W   = bbrb_pkg::SZ_W;
    localparam int FILL_W = bbrb_pkg::FILL_W;
    localparam int BYTE_W = bbrb_pkg::BYTE_W;
    localparam int DATA_W = bbrb_pkg::DATA_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WR   = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_BURST);

    // control registers
    logic [1:0]        r_state, n_state;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic              r_pend, n_pend;
    logic              r_ov, n_ov;
    // payload registers
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_cnt, n_cnt;
    logic [LEN_W-1:0]  r_sent, n_sent;
    logic [LEN_W-1:0]  r_acc, n_acc;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [DATA_W-1:0] r_data, n_data;
    logic [LEN_W-1:0]  r_o_acc, n_o_acc;
    logic [BYTE_W-1:0] r_o_byte, n_o_byte;
    logic              r_o_last, n_o_last;
    logic [FILL_W-1:0] r_o_fill, n_o_fill;

    logic [SZ_W-1:0]   fill9;
    logic [SZ_W-1:0]   space9;
    logic [SZ_W-1:0]   len9;
    logic              len_ok;
    logic              out_free;
    logic              load;
    logic              issue;

    // step a pointer round the ring
    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] ptr,
                                             input logic [SZ_W-1:0] size);
        logic [SZ_W-1:0] nxt;
        nxt = SZ_W'(ptr) + SZ_W'(1);
        return (nxt >= size) ? '0 : PTR_W'(nxt);
    endfunction

    // fill level and free space from the pointers
    always_comb begin
        if (SZ_W'(r_wp) >= SZ_W'(r_rp)) begin
            fill9 = SZ_W'(r_wp) - SZ_W'(r_rp);
        end else begin
            fill9 = SZ_W'(r_wp) + i_cfg.size - SZ_W'(r_rp);
        end
        space9 = i_cfg.size - fill9 - SZ_W'(1);
        len9   = SZ_W'(i_req.transfer_len);
        len_ok = (i_req.transfer_len != '0) && (i_req.transfer_len <= LEN_MAX);
    end

    assign out_free    = !r_ov || o_res.ready;
    assign load        = (r_state == ST_RD) && r_pend && out_free;
    assign issue       = (r_state == ST_RD) && (r_cnt != r_len) && (!r_pend || load);
    assign i_req.ready = (r_state == ST_IDLE);

    // sequencer: write or read a byte a cycle; reads wait for the result register to free
    always_comb begin
        n_state  = r_state;
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_pend   = r_pend;
        n_ov     = r_ov && !o_res.ready;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_sent   = r_sent;
        n_acc    = r_acc;
        n_fill   = r_fill;
        n_data   = r_data;
        n_o_acc  = r_o_acc;
        n_o_byte = r_o_byte;
        n_o_last = r_o_last;
        n_o_fill = r_o_fill;
        o_ram_en    = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_addr  = r_rp;
        o_ram_wdata = r_data[BYTE_W-1:0];

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_len  = i_req.transfer_len;
                    n_data = i_req.write_data;
                    n_cnt  = '0;
                    n_sent = '0;
                    n_acc  = '0;
                    n_fill = FILL_W'(fill9);
                    n_state = ST_RESP;
                    case (i_req.req_type)
                        bbrb_pkg::REQ_WRITE: begin
                            if (len_ok && len9 <= space9) begin
                                n_acc   = i_req.transfer_len;
                                n_fill  = FILL_W'(fill9 + len9);
                                n_state = ST_WR;
                            end
                        end
                        bbrb_pkg::REQ_READ: begin
                            if (len_ok && len9 <= fill9) begin
                                n_acc   = i_req.transfer_len;
                                n_fill  = FILL_W'(fill9 - len9);
                                n_pend  = 1'b0;
                                n_state = ST_RD;
                            end
                        end
                        bbrb_pkg::REQ_CLEAR: begin
                            n_wp   = '0;
                            n_rp   = '0;
                            n_fill = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WR: begin
                o_ram_en   = 1'b1;
                o_ram_we   = 1'b1;
                o_ram_addr = r_wp;
                n_data     = r_data >> BYTE_W;
                n_wp       = adv(r_wp, i_cfg.size);
                n_cnt      = r_cnt + LEN_ONE;
                if (r_cnt + LEN_ONE == r_len) begin
                    n_state = ST_RESP;
                end
            end
            ST_RD: begin
                // a fetched byte holds in the RAM output until the result register frees
                if (issue) begin
                    o_ram_en = 1'b1;
                    n_rp     = adv(r_rp, i_cfg.size);
                    n_cnt    = r_cnt + LEN_ONE;
                    n_pend   = 1'b1;
                end else if (load) begin
                    n_pend = 1'b0;
                end
                if (load) begin
                    n_ov     = 1'b1;
                    n_o_acc  = r_acc;
                    n_o_byte = i_ram_rdata;
                    n_o_last = (r_sent + LEN_ONE == r_len);
                    n_o_fill = r_fill;
                    n_sent   = r_sent + LEN_ONE;
                    if (r_sent + LEN_ONE == r_len) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_o_acc  = r_acc;
                    n_o_byte = '0;
                    n_o_last = 1'b1;
                    n_o_fill = r_fill;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // any configuration write (clear) empties the buffer
        if (i_cfg.clear) begin
            n_wp = '0;
            n_rp = '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp    <= '0;
            r_rp    <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_cnt    <= n_cnt;
        r_sent   <= n_sent;
        r_acc    <= n_acc;
        r_fill   <= n_fill;
        r_data   <= n_data;
        r_o_acc  <= n_o_acc;
        r_o_byte <= n_o_byte;
        r_o_last <= n_o_last;
        r_o_fill <= n_o_fill;
    end

    assign o_res.valid        = r_ov;
    assign o_res.accepted_len = r_o_acc;
    assign o_res.read_byte    = r_o_byte;
    assign o_res.is_last      = r_o_last;
    assign o_res.fill_level   = r_o_fill;

endmodule

/* rtl/burst_byte_ring_buffer_unit.sv */
// burst_byte_ring_buffer_unit: byte FIFO over a circular single-port store, bursts of up to
// MAX_BURST bytes. A write stores its bytes in order; a new item is taken once its single result
// is registered. A read fetches one byte a cycle while the result register is free, registers
// each byte as its own result and takes a new item once the last of them is registered.
// Rejects, clears and unknown requests give one result and free the input once it is registered.
// Synchronous active-low reset empties the buffer, size 256 or DEPTH if smaller.

module burst_byte_ring_buffer_unit #(
    parameter int DEPTH     = bbrb_pkg::DEPTH_DEF,
    parameter int MAX_BURST = bbrb_pkg::MAX_BURST_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [bbrb_pkg::SZ_W-1:0]  i_cfg_data,
    bbrb_req_if.sink                   i_req,
    bbrb_res_if.source                 o_res
);

    localparam int SLOTS = (DEPTH < bbrb_pkg::SLOT_LIMIT) ? DEPTH : bbrb_pkg::SLOT_LIMIT;
    localparam int PTR_W = $clog2(SLOTS);
    localparam logic [bbrb_pkg::SZ_W-1:0] SIZE_MAX = bbrb_pkg::SZ_W'(SLOTS);

    logic [bbrb_pkg::SZ_W-1:0]   r_size, n_size;
    logic                        cfg_wr;
    bbrb_pkg::t_cfg              cfg;
    logic                        ram_en;
    logic                        ram_we;
    logic [PTR_W-1:0]            ram_addr;
    logic [bbrb_pkg::BYTE_W-1:0] ram_wdata;
    logic [bbrb_pkg::BYTE_W-1:0] ram_rdata;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    // clamp the written size to between SIZE_MIN and the slots that exist
    always_comb begin
        n_size = r_size;
        if (cfg_wr) begin
            if (i_cfg_data < bbrb_pkg::SIZE_MIN) begin
                n_size = bbrb_pkg::SIZE_MIN;
            end else if (i_cfg_data > SIZE_MAX) begin
                n_size = SIZE_MAX;
            end else begin
                n_size = i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= (bbrb_pkg::SIZE_RESET > SIZE_MAX) ? SIZE_MAX : bbrb_pkg::SIZE_RESET;
        end else begin
            r_size <= n_size;
        end
    end

    assign cfg.clear = cfg_wr;
    assign cfg.size  = r_size;

    // sequencer and pointers
    bbrb_ctrl #(
        .SLOTS     (SLOTS),
        .MAX_BURST (MAX_BURST)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req       (i_req),
        .o_res       (o_res),
        .o_ram_en    (ram_en),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata)
    );

    // byte store
    bbrb_ram #(
        .WIDTH (bbrb_pkg::BYTE_W),
        .DEPTH (SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

endmodule

/* rtl/bbrb_checker.sv */
// bbrb_checker: port-level assertions for burst_byte_ring_buffer_unit, attached by bind
// depends on bbrb_pkg for field widths

module bbrb_checker #(
    parameter int MAX_BURST = bbrb_pkg::MAX_BURST_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        i_req_ready,
    input logic                        i_res_valid,
    input logic                        i_res_ready,
    input logic [bbrb_pkg::LEN_W-1:0]  i_acc_len,
    input logic [bbrb_pkg::BYTE_W-1:0] i_read_byte,
    input logic                        i_is_last,
    input logic [bbrb_pkg::FILL_W-1:0] i_fill_level
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_acc_len)
            && $stable(i_read_byte) && $stable(i_is_last) && $stable(i_fill_level))
        else $error("result changed while stalled");

    // a result that moved nothing is a single result with no data
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_acc_len == '0 |-> i_is_last && i_read_byte == '0)
        else $error("empty result not single or carries data");

    // no burst longer than the limit
    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_acc_len <= bbrb_pkg::LEN_W'(MAX_BURST))
        else $error("accepted length above burst limit");

    // an accepted item closes the input in the cycle after it is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("input reopened straight after an item");

    // reset leaves no result pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result pending after reset");

endmodule

bind burst_byte_ring_buffer_unit bbrb_checker #(
    .MAX_BURST (MAX_BURST)
) u_bbrb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_acc_len    (o_res.accepted_len),
    .i_read_byte  (o_res.read_byte),
    .i_is_last    (o_res.is_last),
    .i_fill_level (o_res.fill_level)
);
